// ===== rtl/cdgr_pkg.sv =====
// ----------------------------------------------------------------------------
// cdgr_pkg
// Shared types, geometry constants and tables for the CD+G packet renderer.
// ----------------------------------------------------------------------------
package cdgr_pkg;

  // frame geometry
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;
  localparam int PIC_W    = 300;
  localparam int PIC_H    = 216;
  localparam int TILE_W   = 6;
  localparam int TILE_H   = 12;
  localparam int TILE_COLS = 50;
  localparam int TILE_ROWS = 18;
  localparam int SIDE_W   = (SCREEN_W - PIC_W) / 2;
  localparam int RIGHT_W  = SCREEN_W - SIDE_W - PIC_W;
  localparam int BORDER_W = SIDE_W + RIGHT_W;

  localparam int FB_DEPTH = SCREEN_W * SCREEN_H;
  localparam int FB_AW    = $clog2(FB_DEPTH);
  localparam int XW       = $clog2(SCREEN_W);
  localparam int YW       = $clog2(SCREEN_H);

  // first column visited by the border sweep
  localparam int FIRST_BX = (SIDE_W == 0) ? SIDE_W + PIC_W : 0;

  // packet codes
  localparam logic [5:0] CMD_GRAPHICS     = 6'h09;
  localparam logic [5:0] OP_MEM_PRESET    = 6'd1;
  localparam logic [5:0] OP_BORDER_PRESET = 6'd2;
  localparam logic [5:0] OP_TILE_COPY     = 6'd6;
  localparam logic [5:0] OP_TILE_XOR      = 6'd38;
  localparam logic [5:0] OP_PAL_LOW       = 6'd30;
  localparam logic [5:0] OP_PAL_HIGH      = 6'd31;

  // screen row base address for each row of the 216-line picture space
  typedef logic [FB_AW-1:0] row_base_tbl_t [PIC_H];

  function automatic row_base_tbl_t make_row_base();
    row_base_tbl_t tbl;
    for (int i = 0; i < PIC_H; i++) begin
      tbl[i] = FB_AW'(((i * SCREEN_H) / PIC_H) * SCREEN_W);
    end
    return tbl;
  endfunction

  localparam row_base_tbl_t ROW_BASE = make_row_base();

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_BORDER,
    S_TILE_ROW,
    S_TILE_RD,
    S_TILE_WR,
    S_PIX_ADDR,
    S_PIX_READ,
    S_PIX_OUT
  } cdgr_state_t;

  typedef struct packed {
    logic capture;
    logic fill_start;
    logic fill_zero;
    logic fill_step;
    logic border_start;
    logic border_step;
    logic tile_start;
    logic tile_row;
    logic tile_read;
    logic tile_write;
    logic pal_load;
    logic pix_addr;
    logic pix_read;
    logic pix_load;
  } cdgr_cmd_t;

  typedef struct packed {
    logic       is_read;
    logic       cmd_ok;
    logic [5:0] op;
    logic       tile_ok;
    logic       fill_last;
    logic       border_last;
    logic       tile_row_end;
    logic       tile_end;
    logic       out_free;
  } cdgr_status_t;

endpackage

// ===== rtl/cdgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdgr_ctrl
// Sequencer for the renderer: decodes each transaction and steps the datapath.
// ----------------------------------------------------------------------------
module cdgr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cdgr_pkg::cdgr_status_t  status,
  output cdgr_pkg::cdgr_cmd_t     cmd
);
  import cdgr_pkg::*;

  cdgr_state_t state;
  cdgr_state_t state_next;
  logic        tile_xor;

  assign tile_xor = (status.op == OP_TILE_XOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        cmd.fill_zero = 1'b1;
        if (status.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (status.is_read) begin
          state_next = S_PIX_ADDR;
        end else if (status.cmd_ok) begin
          unique case (status.op)
            OP_MEM_PRESET: begin
              cmd.fill_start = 1'b1;
              state_next     = S_FILL;
            end
            OP_BORDER_PRESET: begin
              if (BORDER_W != 0) begin
                cmd.border_start = 1'b1;
                state_next       = S_BORDER;
              end
            end
            OP_TILE_COPY, OP_TILE_XOR: begin
              if (status.tile_ok) begin
                cmd.tile_start = 1'b1;
                state_next     = S_TILE_ROW;
              end
            end
            OP_PAL_LOW, OP_PAL_HIGH: begin
              cmd.pal_load = 1'b1;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_BORDER: begin
        cmd.border_step = 1'b1;
        if (status.border_last) begin
          state_next = S_IDLE;
        end
      end
      S_TILE_ROW: begin
        cmd.tile_row = 1'b1;
        state_next   = tile_xor ? S_TILE_RD : S_TILE_WR;
      end
      S_TILE_RD: begin
        cmd.tile_read = 1'b1;
        state_next    = S_TILE_WR;
      end
      S_TILE_WR: begin
        cmd.tile_write = 1'b1;
        priority if (status.tile_end) begin
          state_next = S_IDLE;
        end else if (status.tile_row_end) begin
          state_next = S_TILE_ROW;
        end else begin
          state_next = tile_xor ? S_TILE_RD : S_TILE_WR;
        end
      end
      S_PIX_ADDR: begin
        cmd.pix_addr = 1'b1;
        state_next   = S_PIX_READ;
      end
      S_PIX_READ: begin
        cmd.pix_read = 1'b1;
        state_next   = S_PIX_OUT;
      end
      S_PIX_OUT: begin
        if (status.out_free) begin
          cmd.pix_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cdgr_datapath.sv =====
// ----------------------------------------------------------------------------
// cdgr_datapath
// Frame memory, palette, address counters and the result register.
// ----------------------------------------------------------------------------
module cdgr_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  cdgr_pkg::cdgr_cmd_t     cmd,
  output cdgr_pkg::cdgr_status_t  status,
  input  logic                    kind,
  input  logic [7:0]              command_byte,
  input  logic [7:0]              instruction_byte,
  input  logic [63:0]             data_low,
  input  logic [63:0]             data_high,
  input  logic [8:0]              read_x,
  input  logic [7:0]              read_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              pixel_index,
  output logic [5:0]              red_level,
  output logic [5:0]              green_level,
  output logic [5:0]              blue_level
);
  import cdgr_pkg::*;

  // captured transaction
  logic         kind_q;
  logic [5:0]   cmd_q;
  logic [5:0]   op_q;
  logic [127:0] data_q;
  logic [8:0]   rx_q;
  logic [7:0]   ry_q;

  // frame memory
  logic [3:0]       fb_mem [FB_DEPTH];
  logic             wr_en;
  logic [FB_AW-1:0] wr_addr;
  logic [3:0]       wr_data;
  logic             rd_en;
  logic [FB_AW-1:0] rd_addr;
  logic [3:0]       rd_data;

  // fill and border sweep
  logic [FB_AW-1:0] fill_addr;
  logic [3:0]       fill_color;
  logic [XW-1:0]    bx;
  logic [YW-1:0]    by;
  logic [FB_AW-1:0] brow_base;
  logic [FB_AW-1:0] border_addr;

  // tile walk
  logic [3:0]       ty;
  logic [2:0]       tx;
  logic [7:0]       tile_sy0;
  logic [7:0]       tile_sy;
  logic [XW-1:0]    tile_x0;
  logic [FB_AW-1:0] trow_base;
  logic [FB_AW-1:0] tile_addr;
  logic [7:0]       tile_bits;
  logic [3:0]       tile_color;
  logic [4:0]       tile_row_sel;
  logic [5:0]       tile_col_sel;

  // palette and pixel read
  logic [11:0]      pal [16];
  logic             pal_hi;
  logic [FB_AW-1:0] pix_addr_q;
  logic             pix_oob;

  assign tile_row_sel = data_q[20:16];
  assign tile_col_sel = data_q[29:24];
  assign tile_sy      = tile_sy0 + 8'(ty);
  assign tile_addr    = trow_base + FB_AW'(tile_x0) + FB_AW'(tx);
  assign tile_bits    = data_q[8 * (4 + int'(ty)) +: 8];
  // bit 5 is the leftmost pixel
  assign tile_color   = tile_bits[3'd5 - tx] ? data_q[11:8] : data_q[3:0];
  assign border_addr  = brow_base + FB_AW'(bx);
  assign pal_hi       = (op_q == OP_PAL_HIGH);

  always_comb begin
    status.is_read      = kind_q;
    status.cmd_ok       = (cmd_q == CMD_GRAPHICS);
    status.op           = op_q;
    status.tile_ok      = (int'(tile_row_sel) < TILE_ROWS) && (int'(tile_col_sel) < TILE_COLS);
    status.fill_last    = (fill_addr == FB_AW'(FB_DEPTH - 1));
    status.border_last  = (by == YW'(SCREEN_H - 1)) && (bx == XW'(SCREEN_W - 1));
    status.tile_row_end = (tx == 3'(TILE_W - 1));
    status.tile_end     = (tx == 3'(TILE_W - 1)) && (ty == 4'(TILE_H - 1));
    status.out_free     = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      cmd_q  <= command_byte[5:0];
      op_q   <= instruction_byte[5:0];
      data_q <= {data_high, data_low};
      rx_q   <= read_x;
      ry_q   <= read_y;
    end
  end

  // write and read port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_addr;
    wr_data = cmd.fill_zero ? 4'd0 : fill_color;
    priority if (cmd.fill_step) begin
      wr_en = 1'b1;
    end else if (cmd.border_step) begin
      wr_en   = 1'b1;
      wr_addr = border_addr;
      wr_data = fill_color;
    end else if (cmd.tile_write) begin
      wr_en   = 1'b1;
      wr_addr = tile_addr;
      wr_data = (op_q == OP_TILE_XOR) ? (rd_data ^ tile_color) : tile_color;
    end else begin
      wr_en = 1'b0;
    end
    rd_en   = cmd.tile_read || cmd.pix_read;
    rd_addr = cmd.tile_read ? tile_addr : pix_addr_q;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fb_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= fb_mem[rd_addr];
    end
  end

  // fill counter also runs the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
    end else if (cmd.fill_start) begin
      fill_addr <= '0;
    end else if (cmd.fill_step) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_start || cmd.border_start) begin
      fill_color <= data_q[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.border_start) begin
      bx        <= XW'(FIRST_BX);
      by        <= '0;
      brow_base <= '0;
    end else if (cmd.border_step) begin
      priority if (bx == XW'(SCREEN_W - 1)) begin
        bx        <= XW'(FIRST_BX);
        by        <= by + 1'b1;
        brow_base <= brow_base + FB_AW'(SCREEN_W);
      end else if ((SIDE_W != 0) && (bx == XW'(SIDE_W - 1))) begin
        // jump over the picture area to the right bar
        bx <= XW'(SIDE_W + PIC_W);
      end else begin
        bx <= bx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tile_start) begin
      ty       <= '0;
      tx       <= '0;
      tile_sy0 <= 8'(tile_row_sel) * 8'(TILE_H);
      tile_x0  <= XW'(tile_col_sel) * XW'(TILE_W) + XW'(SIDE_W);
    end else if (cmd.tile_write) begin
      if (tx == 3'(TILE_W - 1)) begin
        tx <= '0;
        ty <= ty + 1'b1;
      end else begin
        tx <= tx + 1'b1;
      end
    end
    if (cmd.tile_row) begin
      trow_base <= ROW_BASE[tile_sy];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        pal[i] <= '0;
      end
    end else if (cmd.pal_load) begin
      for (int i = 0; i < 8; i++) begin
        pal[{pal_hi, 3'(i)}] <= {data_q[16 * i + 2 +: 4],
                                 data_q[16 * i +: 2], data_q[16 * i + 12 +: 2],
                                 data_q[16 * i + 8 +: 4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_addr) begin
      pix_addr_q <= FB_AW'(ry_q) * FB_AW'(SCREEN_W) + FB_AW'(rx_q);
      pix_oob    <= (int'(rx_q) >= SCREEN_W) || (int'(ry_q) >= SCREEN_H);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pix_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      if (pix_oob) begin
        pixel_index <= '0;
        red_level   <= '0;
        green_level <= '0;
        blue_level  <= '0;
      end else begin
        pixel_index <= rd_data;
        red_level   <= {pal[rd_data][11:8], 2'b00};
        green_level <= {pal[rd_data][7:4], 2'b00};
        blue_level  <= {pal[rd_data][3:0], 2'b00};
      end
    end
  end

endmodule

// ===== rtl/cdg_graphics_packet_renderer.sv =====
// ----------------------------------------------------------------------------
// cdg_graphics_packet_renderer
// CD+G subcode graphics renderer with a 4-bit indexed frame and pixel readback.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries either an 18-byte graphics packet
// (kind = 0) or a pixel read (kind = 1). Output channel (out_valid / out_stall)
// returns one transaction per pixel read: the stored index and its palette
// color as 6-bit levels. Packets produce no output.
// One transaction is worked on at a time; its steps from accept to the next
// accept, after the decode step that every transaction takes:
//   pixel read                       address, memory read, result load
//   palette load, ignored packet     nothing further
//   tile block, copy form            12 rows of a row setup and 6 writes
//   tile block, xor form             as copy, each pixel read then written
//   border preset                    one write per border pixel, row by row
//   memory preset                    one write per frame pixel
// After reset the frame memory is cleared one pixel per cycle, so in_stall
// stays high until all 64000 pixels are cleared; the palette clears at once.
// A result waits in the output register while out_stall is high; packets are
// still accepted meanwhile, and a further read finishes only once it drains.
// ----------------------------------------------------------------------------
module cdg_graphics_packet_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  instruction_byte,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  input  logic [8:0]  read_x,
  input  logic [7:0]  read_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  pixel_index,
  output logic [5:0]  red_level,
  output logic [5:0]  green_level,
  output logic [5:0]  blue_level
);
  import cdgr_pkg::*;

  cdgr_cmd_t    cmd;
  cdgr_status_t status;

  cdgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cdgr_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .kind             (kind),
    .command_byte     (command_byte),
    .instruction_byte (instruction_byte),
    .data_low         (data_low),
    .data_high        (data_high),
    .read_x           (read_x),
    .read_y           (read_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pixel_index      (pixel_index),
    .red_level        (red_level),
    .green_level      (green_level),
    .blue_level       (blue_level)
  );

endmodule

// ===== rtl/cdgr_checker.sv =====
// ----------------------------------------------------------------------------
// cdgr_checker
// Port-level checks for the CD+G renderer, bound to the top level.
// ----------------------------------------------------------------------------
module cdgr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] pixel_index,
  input logic [5:0] red_level,
  input logic [5:0] green_level,
  input logic [5:0] blue_level
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(red_level)
      && $stable(green_level) && $stable(blue_level))
    else $error("stalled result changed");

  // clearing pass keeps the input closed right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input open during clearing pass");

  // one transaction at a time: an accept is always followed by a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("back-to-back accept");

  // a new result only comes out of a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in work");

  // color levels are 4-bit palette values scaled by four
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_level[1:0] == 2'b00) && (green_level[1:0] == 2'b00)
      && (blue_level[1:0] == 2'b00))
    else $error("color level not a multiple of four");

endmodule

bind cdg_graphics_packet_renderer cdgr_checker u_cdgr_checker (.*);
